>>> hdl/bptc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared widths, constants and register indexes for the barometric pressure
// and temperature compensation pipeline.
// ----------------------------------------------------------------------------
package bptc_pkg;

	localparam int STAGES = 10;

	localparam int RAW_W  = 24;
	localparam int COEF_W = 16;
	localparam int TEMP_W = 19;
	localparam int PRES_W = 32;
	localparam int IDX_W  = 3;

	// dT and the wide intermediates
	localparam int DT_W   = 25;
	localparam int PROD_W = 42;
	localparam int SQ_W   = 50;
	localparam int TM_W   = 19;
	localparam int ACC_W  = 42;

	localparam int SH_TEMP = 23;
	localparam int SH_OFF  = 6;
	localparam int SH_SENS = 7;
	localparam int SH_T2   = 31;
	localparam int SH_MUL  = 21;
	localparam int SH_P    = 15;

	localparam logic signed [TM_W-1:0] TEMP_BASE  = 19'sd2000;
	// TEMP + 1500 expressed relative to TEMP - 2000
	localparam logic signed [TM_W-1:0] COLD_OFS   = 19'sd3500;
	localparam logic signed [TM_W-1:0] VCOLD_LIM  = -19'sd3500;

	typedef enum logic [IDX_W-1:0] {
		REG_SENS      = 3'd0,
		REG_OFF       = 3'd1,
		REG_SENS_TC   = 3'd2,
		REG_OFF_TC    = 3'd3,
		REG_TREF      = 3'd4,
		REG_TEMP_COEF = 3'd5
	} reg_idx_t;

endpackage

>>> hdl/baro_pressure_temp_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Ten-stage pipeline turning raw pressure/temperature readings and six
// calibration words into compensated temperature (0.01 degC) and pressure (Pa).
// ----------------------------------------------------------------------------
// Accepts one transaction per clock unless stalled by the output side, and
// delivers one result per transaction. The depth is set by the chain of
// registered multipliers: dT products, the two squares of the low-temperature
// correction, the constant scaling, and the final raw pressure by sensitivity
// product, which is split into two partial products. Each stage holds its
// transaction independently, so a stalled output only holds back the stages
// behind it once they are full. The user must write calibration words through
// the cfg port only while no transaction is in flight; this is not enforced.
module baro_pressure_temp_compensation (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [bptc_pkg::IDX_W-1:0]           cfg_index,
	input  logic [bptc_pkg::COEF_W-1:0]          cfg_wr_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [bptc_pkg::RAW_W-1:0]           raw_pressure,
	input  logic [bptc_pkg::RAW_W-1:0]           raw_temperature,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [bptc_pkg::TEMP_W-1:0]   temperature_centi,
	output logic signed [bptc_pkg::PRES_W-1:0]   pressure_pa
);

	localparam int NS = bptc_pkg::STAGES;

	// calibration
	logic [15:0] sens_q, off_q, sens_tc_q, off_tc_q, tref_q, temp_coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q      <= '0;
			off_q       <= '0;
			sens_tc_q   <= '0;
			off_tc_q    <= '0;
			tref_q      <= '0;
			temp_coef_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bptc_pkg::REG_SENS:      sens_q      <= cfg_wr_data;
				bptc_pkg::REG_OFF:       off_q       <= cfg_wr_data;
				bptc_pkg::REG_SENS_TC:   sens_tc_q   <= cfg_wr_data;
				bptc_pkg::REG_OFF_TC:    off_tc_q    <= cfg_wr_data;
				bptc_pkg::REG_TREF:      tref_q      <= cfg_wr_data;
				bptc_pkg::REG_TEMP_COEF: temp_coef_q <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	// stage control
	logic [NS:1] stage_valid_q;
	logic [NS:1] adv;
	logic [NS:0] vin;

	always_comb begin
		adv[NS] = !stage_valid_q[NS] || out_ready;
		for (int k = NS - 1; k >= 1; k--) begin
			adv[k] = !stage_valid_q[k] || adv[k+1];
		end
		vin = {stage_valid_q, in_valid};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (adv[k]) stage_valid_q[k] <= vin[k-1];
			end
		end
	end

	assign in_ready  = adv[1];
	assign out_valid = stage_valid_q[NS];

	// stage 1: dT
	logic signed [bptc_pkg::DT_W-1:0] dt_s1;
	logic [bptc_pkg::RAW_W-1:0]       rawp_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			dt_s1   <= $signed({1'b0, raw_temperature}) - $signed({1'b0, tref_q, 8'd0});
			rawp_s1 <= raw_pressure;
		end
	end

	// stage 2: dT products
	logic signed [bptc_pkg::PROD_W-1:0] pt_s2, po_s2, ps_s2;
	logic signed [bptc_pkg::SQ_W-1:0]   dtsq_s2;
	logic [bptc_pkg::RAW_W-1:0]         rawp_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			pt_s2   <= bptc_pkg::PROD_W'(dt_s1) *
				bptc_pkg::PROD_W'($signed({1'b0, temp_coef_q}));
			po_s2   <= bptc_pkg::PROD_W'(dt_s1) *
				bptc_pkg::PROD_W'($signed({1'b0, off_tc_q}));
			ps_s2   <= bptc_pkg::PROD_W'(dt_s1) *
				bptc_pkg::PROD_W'($signed({1'b0, sens_tc_q}));
			dtsq_s2 <= bptc_pkg::SQ_W'(dt_s1) * bptc_pkg::SQ_W'(dt_s1);
			rawp_s2 <= rawp_s1;
		end
	end

	// stage 3: first-order terms
	logic signed [bptc_pkg::TM_W-1:0]  tm_c;
	logic signed [bptc_pkg::TM_W-1:0]  tm_s3, tp_s3, temp_s3;
	logic signed [bptc_pkg::ACC_W-1:0] off_s3, sens_s3;
	logic [16:0]                       t2_s3;
	logic                              cold_s3, vcold_s3;
	logic [bptc_pkg::RAW_W-1:0]        rawp_s3;

	assign tm_c = bptc_pkg::TM_W'(pt_s2 >>> bptc_pkg::SH_TEMP);

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			tm_s3    <= tm_c;
			tp_s3    <= tm_c + bptc_pkg::COLD_OFS;
			temp_s3  <= tm_c + bptc_pkg::TEMP_BASE;
			cold_s3  <= tm_c[bptc_pkg::TM_W-1];
			vcold_s3 <= tm_c < bptc_pkg::VCOLD_LIM;
			off_s3   <= $signed({9'd0, off_q, 17'd0}) + (po_s2 >>> bptc_pkg::SH_OFF);
			sens_s3  <= $signed({10'd0, sens_q, 16'd0}) + (ps_s2 >>> bptc_pkg::SH_SENS);
			t2_s3    <= dtsq_s2[47:bptc_pkg::SH_T2];
			rawp_s3  <= rawp_s2;
		end
	end

	// stage 4: squares
	logic signed [37:0] tm2_c, tp2_c;
	logic [35:0] tm2_s4, tp2_s4;
	logic signed [bptc_pkg::TM_W-1:0]  temp_s4;
	logic signed [bptc_pkg::ACC_W-1:0] off_s4, sens_s4;
	logic [16:0]                       t2_s4;
	logic                              cold_s4, vcold_s4;
	logic [bptc_pkg::RAW_W-1:0]        rawp_s4;

	assign tm2_c = 38'(tm_s3) * 38'(tm_s3);
	assign tp2_c = 38'(tp_s3) * 38'(tp_s3);

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			tm2_s4   <= tm2_c[35:0];
			tp2_s4   <= tp2_c[35:0];
			temp_s4  <= temp_s3;
			off_s4   <= off_s3;
			sens_s4  <= sens_s3;
			t2_s4    <= t2_s3;
			cold_s4  <= cold_s3;
			vcold_s4 <= vcold_s3;
			rawp_s4  <= rawp_s3;
		end
	end

	// stage 5: constant scaling of the squares
	logic [41:0] m61_c;
	logic [39:0] m15_c;
	logic [37:0] off2a_s5;
	logic [39:0] off2b_s5;
	logic [36:0] sens2a_s5;
	logic [38:0] sens2b_s5;
	logic signed [bptc_pkg::TM_W-1:0]  temp_s5;
	logic signed [bptc_pkg::ACC_W-1:0] off_s5, sens_s5;
	logic [16:0]                       t2_s5;
	logic                              cold_s5;
	logic [bptc_pkg::RAW_W-1:0]        rawp_s5;

	assign m61_c = {tm2_s4, 6'd0} - {4'd0, tm2_s4, 2'd0} + {6'd0, tm2_s4};
	assign m15_c = {tp2_s4, 4'd0} - {4'd0, tp2_s4};

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			off2a_s5  <= m61_c[41:4];
			off2b_s5  <= vcold_s4 ? m15_c : '0;
			sens2a_s5 <= {tm2_s4, 1'b0};
			sens2b_s5 <= vcold_s4 ? {tp2_s4, 3'd0} : '0;
			temp_s5   <= temp_s4;
			off_s5    <= off_s4;
			sens_s5   <= sens_s4;
			t2_s5     <= t2_s4;
			cold_s5   <= cold_s4;
			rawp_s5   <= rawp_s4;
		end
	end

	// stage 6: second-order offset and sensitivity
	logic [40:0] off2_s6;
	logic [39:0] sens2_s6;
	logic signed [bptc_pkg::TM_W-1:0]  temp_s6;
	logic signed [bptc_pkg::ACC_W-1:0] off_s6, sens_s6;
	logic [16:0]                       t2_s6;
	logic                              cold_s6;
	logic [bptc_pkg::RAW_W-1:0]        rawp_s6;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			off2_s6  <= {3'd0, off2a_s5} + {1'b0, off2b_s5};
			sens2_s6 <= {3'd0, sens2a_s5} + {1'b0, sens2b_s5};
			temp_s6  <= temp_s5;
			off_s6   <= off_s5;
			sens_s6  <= sens_s5;
			t2_s6    <= t2_s5;
			cold_s6  <= cold_s5;
			rawp_s6  <= rawp_s5;
		end
	end

	// stage 7: apply correction
	logic signed [bptc_pkg::TM_W-1:0]  temp_s7;
	logic signed [bptc_pkg::ACC_W-1:0] off_s7, sens_s7;
	logic                              cold_s7;
	logic [bptc_pkg::RAW_W-1:0]        rawp_s7;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			temp_s7 <= cold_s6 ? temp_s6 - $signed({2'd0, t2_s6}) : temp_s6;
			off_s7  <= cold_s6 ? off_s6 - $signed({1'b0, off2_s6}) : off_s6;
			sens_s7 <= cold_s6 ? sens_s6 - $signed({2'd0, sens2_s6}) : sens_s6;
			cold_s7 <= cold_s6;
			rawp_s7 <= rawp_s6;
		end
	end

	// stage 8: raw pressure by sensitivity, two partial products
	logic [44:0]                       plo_s8;
	logic signed [45:0]                phi_s8;
	logic signed [bptc_pkg::TM_W-1:0]  temp_s8;
	logic signed [bptc_pkg::ACC_W-1:0] off_s8;

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			plo_s8  <= 45'(rawp_s7) * 45'(sens_s7[bptc_pkg::SH_MUL-1:0]);
			phi_s8  <= 46'($signed({1'b0, rawp_s7})) *
				46'($signed(sens_s7[41:bptc_pkg::SH_MUL]));
			temp_s8 <= temp_s7;
			off_s8  <= off_s7;
		end
	end

	// stage 9: floor(raw_p * SENS / 2^21)
	logic signed [46:0]                q_s9;
	logic signed [bptc_pkg::TM_W-1:0]  temp_s9;
	logic signed [bptc_pkg::ACC_W-1:0] off_s9;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			q_s9    <= 47'(phi_s8) + $signed({23'd0, plo_s8[44:bptc_pkg::SH_MUL]});
			temp_s9 <= temp_s8;
			off_s9  <= off_s8;
		end
	end

	// stage 10: output register
	logic signed [47:0]                diff_c;
	logic signed [bptc_pkg::PRES_W-1:0] pres_s10;
	logic signed [bptc_pkg::TM_W-1:0]  temp_s10;

	assign diff_c = 48'(q_s9) - 48'(off_s9);

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			pres_s10 <= diff_c[bptc_pkg::SH_P+bptc_pkg::PRES_W-1:bptc_pkg::SH_P];
			temp_s10 <= temp_s9;
		end
	end

	assign pressure_pa       = pres_s10;
	assign temperature_centi = temp_s10;

	// checks
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> stage_valid_q[1])
		else $error("accepted transaction did not enter stage 1");

	a_hold_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((stage_valid_q & $past(stage_valid_q & ~adv)) ==
			$past(stage_valid_q & ~adv)))
		else $error("held transaction dropped from pipeline");

	a_warm_temp: assert property (@(posedge clk) disable iff (!arst_n)
		stage_valid_q[7] && !cold_s7 |-> temp_s7 >= bptc_pkg::TEMP_BASE)
		else $error("uncorrected temperature below 20.00 degrees");

endmodule
